### rtl/core/atrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg - shared types and constants of the tilt angle unit
// Widths of the scaled axes, the square-root and rotation datapaths, the
// record that passes from the front end to the angle pipelines, and the
// arctangent table in degrees with 16 fraction bits.
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned AxisW     = 12;
  localparam int unsigned SumW      = 24;
  localparam int unsigned RootW     = 28;
  localparam int unsigned RemW      = 30;
  localparam int unsigned FracW     = 16;
  localparam int unsigned CxW       = 31;
  localparam int unsigned AccW      = 25;
  localparam int unsigned AtanW     = 22;
  localparam int unsigned DegW      = 8;
  localparam int unsigned TabLen    = 24;
  localparam int unsigned FifoDepth = 2;

  localparam logic [DegW-2:0] DegMax = 7'd90;

  typedef struct packed {
    logic neg;    // numerator is negative
    logic nzero;  // numerator is zero
    logic dzero;  // denominator is zero
  } atrp_angctl_t;

  typedef struct packed {
    logic [AxisW-1:0] mag;  // numerator magnitude
    logic [SumW-1:0]  sum;  // sum of squares under the root
    atrp_angctl_t     ctl;
  } atrp_ang_t;

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
    atrp_ang_t               roll;
    atrp_ang_t               pitch;
  } atrp_item_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [AtanW-1:0] atrp_atan(input logic [4:0] idx);
    logic [AtanW-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/atrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_front - sample intake and classification
// Scales the raw axis words toward zero by 16, then forms the magnitudes,
// the sums of squares and the zero/sign flags of both angles.
// ----------------------------------------------------------------------------
module atrp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [atrp_pkg::WordW-1:0]    x_word_i,
  input  logic [atrp_pkg::WordW-1:0]    y_word_i,
  input  logic [atrp_pkg::WordW-1:0]    z_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output atrp_pkg::atrp_item_t          out_item_o
);

  localparam int unsigned AxisW = atrp_pkg::AxisW;
  localparam int unsigned WordW = atrp_pkg::WordW;

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [AxisW-1:0]  x1_q, y1_q, z1_q;
  logic signed [AxisW-1:0]  xs, ys, zs;
  logic [AxisW-1:0]         mx, my, mz;
  logic [2*AxisW-1:0]       sqx, sqy, sqz;
  logic [atrp_pkg::SumW-1:0] sum_roll, sum_pitch;
  atrp_pkg::atrp_item_t     item_d, item_q;

  function automatic logic signed [AxisW-1:0] scale16(input logic [WordW-1:0] w);
    logic signed [WordW:0] ws;
    ws = $signed({w[WordW-1], w}) + (w[WordW-1] ? 17'sd15 : 17'sd0);
    return ws[WordW-1:4];
  endfunction

  assign xs = scale16(x_word_i);
  assign ys = scale16(y_word_i);
  assign zs = scale16(z_word_i);

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign mx = x1_q[AxisW-1] ? AxisW'(-x1_q) : x1_q;
  assign my = y1_q[AxisW-1] ? AxisW'(-y1_q) : y1_q;
  assign mz = z1_q[AxisW-1] ? AxisW'(-z1_q) : z1_q;

  assign sqx = mx * mx;
  assign sqy = my * my;
  assign sqz = mz * mz;

  assign sum_roll  = sqx + sqz;
  assign sum_pitch = sqy + sqz;

  always_comb begin
    item_d                 = '0;
    item_d.x               = x1_q;
    item_d.y               = y1_q;
    item_d.z               = z1_q;
    item_d.roll.mag        = my;
    item_d.roll.sum        = sum_roll;
    item_d.roll.ctl.neg    = y1_q[AxisW-1];
    item_d.roll.ctl.nzero  = (y1_q == '0);
    item_d.roll.ctl.dzero  = (sum_roll == '0);
    // pitch uses -x as its numerator
    item_d.pitch.mag       = mx;
    item_d.pitch.sum       = sum_pitch;
    item_d.pitch.ctl.neg   = !x1_q[AxisW-1] && (x1_q != '0);
    item_d.pitch.ctl.nzero = (x1_q == '0);
    item_d.pitch.ctl.dzero = (sum_pitch == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      x1_q <= xs;
      y1_q <= ys;
      z1_q <= zs;
    end
    if (en2 && v1_q) item_q <= item_d;
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item_q;

endmodule

### rtl/core/atrp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_fifo - short queue between front end and angle pipelines
// Two-entry register queue; lets either side stall on its own.
// ----------------------------------------------------------------------------
module atrp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  atrp_pkg::atrp_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output atrp_pkg::atrp_item_t out_item_o
);

  localparam int unsigned Depth = atrp_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  atrp_pkg::atrp_item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem[wr_ptr_q] <= in_item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count overflow");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("queue count did not advance on request");

endmodule

### rtl/core/atrp_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_angle - pipelined atan2(n, sqrt(s)) in whole degrees
// One root digit per stage for the denominator, then one CORDIC vectoring
// step per stage, then truncation, clamping and sign fix-up.
// ----------------------------------------------------------------------------
module atrp_angle #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  atrp_pkg::atrp_ang_t               ang_i,
  output logic signed [atrp_pkg::DegW-1:0]  deg_o
);

  localparam int unsigned RootW = atrp_pkg::RootW;
  localparam int unsigned RemW  = atrp_pkg::RemW;
  localparam int unsigned SumW  = atrp_pkg::SumW;
  localparam int unsigned AxisW = atrp_pkg::AxisW;
  localparam int unsigned CxW   = atrp_pkg::CxW;
  localparam int unsigned AccW  = atrp_pkg::AccW;
  localparam int unsigned FracW = atrp_pkg::FracW;
  localparam int unsigned DegW  = atrp_pkg::DegW;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned Sq    = RootW;
  localparam int unsigned Cs    = (CORDIC_STEPS > atrp_pkg::TabLen) ?
                                  atrp_pkg::TabLen : CORDIC_STEPS;

  logic [RemW-1:0]            rem_q  [Sq];
  logic [RootW-1:0]           root_q [Sq];
  logic [SumW-1:0]            sum_q  [Sq];
  logic [AxisW-1:0]           mag_q  [Sq];
  logic signed [CxW-1:0]      cx_q   [Cs];
  logic signed [CxW-1:0]      cy_q   [Cs];
  logic signed [AccW-1:0]     acc_q  [Cs];
  atrp_pkg::atrp_angctl_t     ctl_q  [Sq+Cs];
  logic signed [DegW-1:0]     deg_q;

  for (genvar k = 0; k < Sq; k++) begin : g_sqrt
    logic [RemW-1:0]    rem_in;
    logic [RootW-1:0]   root_in;
    logic [SumW-1:0]    sum_in;
    logic [AxisW-1:0]   mag_in;
    atrp_pkg::atrp_angctl_t ctl_in;
    logic [RadW-1:0]    rad;
    logic [RemW+1:0]    r2, trial, diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sum_in  = ang_i.sum;
      assign mag_in  = ang_i.mag;
      assign ctl_in  = ang_i.ctl;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sum_in  = sum_q[k-1];
      assign mag_in  = mag_q[k-1];
      assign ctl_in  = ctl_q[k-1];
    end

    // bring down the next two radicand bits, try the next root bit
    assign rad   = {sum_in, {(RadW-SumW){1'b0}}};
    assign r2    = {rem_in, rad[RadW-1-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = r2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r2 >= trial) begin
          rem_q[k]  <= diff[RemW-1:0];
          root_q[k] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= r2[RemW-1:0];
          root_q[k] <= {root_in[RootW-2:0], 1'b0};
        end
        sum_q[k] <= sum_in;
        mag_q[k] <= mag_in;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  for (genvar j = 0; j < Cs; j++) begin : g_cordic
    logic signed [CxW-1:0]  x_in, y_in, xs, ys;
    logic signed [AccW-1:0] a_in, step;

    if (j == 0) begin : g_first
      assign x_in = $signed({{(CxW-RootW){1'b0}}, root_q[Sq-1]});
      assign y_in = $signed({{(CxW-AxisW-FracW){1'b0}}, mag_q[Sq-1], {FracW{1'b0}}});
      assign a_in = '0;
    end else begin : g_next
      assign x_in = cx_q[j-1];
      assign y_in = cy_q[j-1];
      assign a_in = acc_q[j-1];
    end

    assign xs   = x_in >>> j;
    assign ys   = y_in >>> j;
    assign step = $signed({{(AccW-atrp_pkg::AtanW){1'b0}}, atrp_pkg::atrp_atan(5'(j))});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[CxW-1]) begin
          cx_q[j]  <= x_in + ys;
          cy_q[j]  <= y_in - xs;
          acc_q[j] <= a_in + step;
        end else begin
          cx_q[j]  <= x_in - ys;
          cy_q[j]  <= y_in + xs;
          acc_q[j] <= a_in - step;
        end
        ctl_q[Sq+j] <= ctl_q[Sq+j-1];
      end
    end
  end

  logic signed [AccW-1:0]   acc_fin;
  atrp_pkg::atrp_angctl_t   ctl_fin;
  logic [AccW-FracW-2:0]    whole;
  logic [DegW-2:0]          mdeg;
  logic signed [DegW-1:0]   deg_d;

  assign acc_fin = acc_q[Cs-1];
  assign ctl_fin = ctl_q[Sq+Cs-1];
  assign whole   = acc_fin[AccW-2:FracW];

  always_comb begin
    if (acc_fin[AccW-1])                            mdeg = '0;
    else if (whole > (AccW-FracW-1)'(atrp_pkg::DegMax)) mdeg = atrp_pkg::DegMax;
    else                                            mdeg = whole[DegW-2:0];
    priority if (ctl_fin.nzero) deg_d = '0;
    else if (ctl_fin.dzero)     deg_d = ctl_fin.neg ? -$signed({1'b0, atrp_pkg::DegMax})
                                                    :  $signed({1'b0, atrp_pkg::DegMax});
    else if (ctl_fin.neg)       deg_d = -$signed({1'b0, mdeg});
    else                        deg_d = $signed({1'b0, mdeg});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) deg_q <= deg_d;
  end

  assign deg_o = deg_q;

endmodule

### rtl/core/atrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_back - angle execution
// Runs roll and pitch through two angle pipelines side by side and carries
// the scaled axes alongside; the last stage doubles as the output register.
// ----------------------------------------------------------------------------
module atrp_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  atrp_pkg::atrp_item_t              in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [atrp_pkg::AxisW-1:0] x_scaled_o,
  output logic signed [atrp_pkg::AxisW-1:0] y_scaled_o,
  output logic signed [atrp_pkg::AxisW-1:0] z_scaled_o,
  output logic signed [atrp_pkg::DegW-1:0]  roll_deg_o,
  output logic signed [atrp_pkg::DegW-1:0]  pitch_deg_o
);

  localparam int unsigned AxisW = atrp_pkg::AxisW;
  localparam int unsigned Cs    = (CORDIC_STEPS > atrp_pkg::TabLen) ?
                                  atrp_pkg::TabLen : CORDIC_STEPS;
  localparam int unsigned Lat   = atrp_pkg::RootW + Cs + 1;

  logic                 en;
  logic                 vld_q [Lat];
  logic [3*AxisW-1:0]   axes_q [Lat];

  assign en         = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;

  atrp_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (in_item_i.roll),
    .deg_o (roll_deg_o)
  );

  atrp_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (in_item_i.pitch),
    .deg_o (pitch_deg_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      axes_q[0] <= {in_item_i.z, in_item_i.y, in_item_i.x};
      for (int i = 1; i < Lat; i++) axes_q[i] <= axes_q[i-1];
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign x_scaled_o  = axes_q[Lat-1][AxisW-1:0];
  assign y_scaled_o  = axes_q[Lat-1][2*AxisW-1:AxisW];
  assign z_scaled_o  = axes_q[Lat-1][3*AxisW-1:2*AxisW];

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_deg_o >= -8'sd90 && roll_deg_o <= 8'sd90))
    else $error("roll out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[Lat-1]))
    else $error("pipeline moved while stalled");

endmodule

### rtl/core/accel_tilt_roll_pitch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_top - roll and pitch from one accelerometer sample
// Pipeline from input accept to result valid: 2 front stages, the queue,
//   28 root stages, one stage per CORDIC step, 1 output stage.
// Throughput: one sample per cycle unless the output stalls; set by the
//   fully pipelined root and rotation stages, each a register stage of its own.
// Reset clears all valid and queue state; no payload is reset.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // x_word[15:0], y_word[31:16], z_word[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // x_scaled[11:0], y_scaled[23:12],
                                      // z_scaled[35:24], roll_deg[43:36],
                                      // pitch_deg[51:44], zero[55:52]
);

  logic                              f_valid, f_ready;
  logic                              q_valid, q_ready;
  atrp_pkg::atrp_item_t              f_item, q_item;
  logic signed [atrp_pkg::AxisW-1:0] x_s, y_s, z_s;
  logic signed [atrp_pkg::DegW-1:0]  roll, pitch;

  atrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .x_word_i    (s_axis_tdata[15:0]),
    .y_word_i    (s_axis_tdata[31:16]),
    .z_word_i    (s_axis_tdata[47:32]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  atrp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  atrp_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_scaled_o  (x_s),
    .y_scaled_o  (y_s),
    .z_scaled_o  (z_s),
    .roll_deg_o  (roll),
    .pitch_deg_o (pitch)
  );

  assign m_axis_tdata = {4'b0000, pitch, roll, z_s, y_s, x_s};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stream test of the accelerometer roll and pitch unit
// Drives random and corner-case samples with random idle gaps on both sides
// and one long output hold-off. An in-bench CORDIC predictor computes each
// expected result, and a scoreboard checks the results in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Steps     = 16;
  localparam int unsigned Latency   = Steps + 32;
  localparam int unsigned NumRandom = 400;
  localparam longint      CycleCap  = 400000;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] z;
    logic [7:0]  roll;
    logic [7:0]  pitch;
  } tilt_res_t;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint AtanDeg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic int scale_axis(logic [15:0] w);
    int v;
    v = $signed(w);
    return v < 0 ? -((-v) / 16) : v / 16;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic int tilt_deg(int n, int a, int b);
    longint sum;
    longint xv;
    longint yv;
    longint acc;
    longint xs;
    longint ys;
    int deg;
    int steps;
    if (n == 0) return 0;
    sum = longint'(a) * a + longint'(b) * b;
    if (sum == 0) return n < 0 ? -90 : 90;
    xv = root_floor(sum <<< 32);
    yv = longint'(n < 0 ? -n : n) * 65536;
    acc = 0;
    steps = Steps > 24 ? 24 : Steps;
    for (int i = 0; i < steps; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        acc += AtanDeg[i];
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        acc -= AtanDeg[i];
      end
    end
    deg = acc < 0 ? 0 : int'(acc / 65536);
    if (deg > 90) deg = 90;
    return n < 0 ? -deg : deg;
  endfunction

  class tilt_scoreboard;
    tilt_res_t pending_q[$];
    int errors;
    int checked;

    function void note_sample(logic [47:0] d);
      tilt_res_t r;
      int x;
      int y;
      int z;
      x = scale_axis(d[15:0]);
      y = scale_axis(d[31:16]);
      z = scale_axis(d[47:32]);
      r.x = x[11:0];
      r.y = y[11:0];
      r.z = z[11:0];
      r.roll = 8'(tilt_deg(y, x, z));
      r.pitch = 8'(tilt_deg(-x, y, z));
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [55:0] d);
      tilt_res_t e;
      tilt_res_t a;
      a = {d[11:0], d[23:12], d[35:24], d[43:36], d[51:44]};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.x !== e.x) begin
        $display("%0t: x_scaled exp %h got %h", $realtime, e.x, a.x);
        errors++;
      end
      if (a.y !== e.y) begin
        $display("%0t: y_scaled exp %h got %h", $realtime, e.y, a.y);
        errors++;
      end
      if (a.z !== e.z) begin
        $display("%0t: z_scaled exp %h got %h", $realtime, e.z, a.z);
        errors++;
      end
      if (a.roll !== e.roll) begin
        $display("%0t: roll exp %0d got %0d", $realtime, $signed(e.roll), $signed(a.roll));
        errors++;
      end
      if (a.pitch !== e.pitch) begin
        $display("%0t: pitch exp %0d got %0d", $realtime, $signed(e.pitch),
                 $signed(a.pitch));
        errors++;
      end
      if (d[55:52] !== 4'd0) begin
        $display("%0t: pad exp 0 got %h", $realtime, d[55:52]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [47:0] in_data;
  logic        out_valid;
  logic        out_ready;
  logic [55:0] out_data;
  logic        idle_off;
  logic        hold_req;
  longint      cycle_cnt;
  tilt_scoreboard sb;

  accel_tilt_roll_pitch_top #(.CORDIC_STEPS(Steps)) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    idle_off = 1'b0;
    hold_req = 1'b0;
    cycle_cnt = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample both handshakes at the edge, before the new drive takes effect
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_sample(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int n;
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {z, y, x};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 31));
      1: return 16'h7FFF - 16'($urandom_range(0, 31));
      2: return 16'($signed($urandom_range(0, 63)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corner [8];
    corner = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h000F, 16'hFFF1,
               16'h0010, 16'hFFF0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // zero numerator, zero denominator, atan2(0,0), word extremes
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h4000, 16'h0000);
    send_sample(16'h0000, 16'hC000, 16'h0000);
    send_sample(16'h4000, 16'h0000, 16'h0000);
    send_sample(16'hC000, 16'h0000, 16'h0000);
    send_sample(16'h000F, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h0010);
    send_sample(16'h7FFF, 16'h8000, 16'hFFF0);
    send_sample(16'h0010, 16'h7FFF, 16'h0000);
    send_sample(16'h7FFF, 16'h0010, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h7FFF);
    send_sample(16'hFFF1, 16'h000F, 16'h8000);
    for (int i = 0; i < 8; i++) send_sample(corner[i], corner[7 - i], corner[(i + 3) % 8]);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 100) hold_req = 1'b1;
      if (i == NumRandom - 60) idle_off = 1'b1;
      send_sample(rand_word(), rand_word(), rand_word());
    end
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Checked %0d samples: axis extremes, zero cases, random tilts,", sb.checked);
    $display("with idle bursts on both sides and one long output hold-off.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### accel_tilt_roll_pitch_top.f
rtl/core/atrp_pkg.sv
rtl/core/atrp_front.sv
rtl/core/atrp_fifo.sv
rtl/core/atrp_angle.sv
rtl/core/atrp_back.sv
rtl/core/accel_tilt_roll_pitch_top.sv
tb/tb_top.sv
